>>> hw/rtl/pfba_pkg.sv
// Shared types, constants and a helper function of the page frame bitmap allocator.
package pfba_pkg;

  localparam int unsigned FRAME_W          = 15;
  localparam int unsigned DIV_W            = 32;
  localparam int unsigned SPACE_W          = 28;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned BIT_IDX_W        = 5;
  localparam int unsigned ROW_IDX_W        = 5;
  localparam int unsigned WORD_IDX_W       = FRAME_W - BIT_IDX_W;
  localparam int unsigned MAX_WORDS        = 1 << WORD_IDX_W;
  localparam int unsigned BITMAP_WORDS_DEF = 1024;
  localparam int unsigned COUNT_W          = 16;
  localparam int unsigned PAGE_SHIFT       = 12;
  localparam int unsigned OP_W             = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef struct packed {
    logic [FRAME_W-1:0] alloc_frame;
    logic               found;
    logic [SPACE_W-1:0] free_space;
  } result_t;

  typedef struct packed {
    logic               start;
    logic [SPACE_W-1:0] dividend;
    logic [DIV_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SPACE_W-1:0] quotient;
  } div_rsp_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hw/rtl/pfba_divider.sv
// Restoring divider, one quotient bit per cycle, for the free-space query.
module pfba_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfba_pkg::div_req_t  req_i,
  output pfba_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned STEPS = pfba_pkg::SPACE_W;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [pfba_pkg::DIV_W-1:0]   rem_q, rem_d;
  logic [pfba_pkg::SPACE_W-1:0] quo_q, quo_d;
  logic [pfba_pkg::DIV_W-1:0]   div_q, div_d;

  logic [pfba_pkg::DIV_W:0]     shifted;
  logic [pfba_pkg::DIV_W:0]     diff;
  logic                         ge;

  assign shifted = {rem_q, quo_q[pfba_pkg::SPACE_W-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift the next dividend bit in, subtract when it fits
      rem_d = ge ? diff[pfba_pkg::DIV_W-1:0] : shifted[pfba_pkg::DIV_W-1:0];
      quo_d = {quo_q[pfba_pkg::SPACE_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> hw/rtl/pfba_core.sv
// Bitmap and summary memories with the read-modify-write sequencer and free count.
module pfba_core #(
  parameter int unsigned BITMAP_WORDS = pfba_pkg::BITMAP_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pfba_pkg::op_e                 in_op_i,
  input  logic [pfba_pkg::FRAME_W-1:0]  in_frame_i,
  input  logic [pfba_pkg::DIV_W-1:0]    in_divisor_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output pfba_pkg::result_t             res_o
);

  // Frame numbers reach only MAX_WORDS words; words beyond are not instantiated.
  localparam int unsigned WORDS = (BITMAP_WORDS < pfba_pkg::MAX_WORDS) ?
                                  BITMAP_WORDS : pfba_pkg::MAX_WORDS;
  localparam int unsigned WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SR    = (WORDS + pfba_pkg::WORD_W - 1) / pfba_pkg::WORD_W;
  localparam int unsigned SRA   = (SR > 1) ? $clog2(SR) : 1;
  localparam logic [pfba_pkg::WORD_IDX_W:0] WORDS_LIM = (pfba_pkg::WORD_IDX_W + 1)'(WORDS);
  localparam logic [pfba_pkg::COUNT_W-1:0]  FRAME_LIM =
    pfba_pkg::COUNT_W'(WORDS * pfba_pkg::WORD_W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ASUM = 5'b00010,
    ST_RMW  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e                           state_q, state_d;
  pfba_pkg::op_e                    op_q, op_d;
  logic [pfba_pkg::ROW_IDX_W-1:0]   row_q, row_d;
  logic [pfba_pkg::BIT_IDX_W-1:0]   col_q, col_d;
  logic [pfba_pkg::BIT_IDX_W-1:0]   bit_q, bit_d;
  logic                             in_range_q, in_range_d;
  logic [pfba_pkg::COUNT_W-1:0]     free_q, free_d;
  logic [SR-1:0]                    top_q, top_d;
  pfba_pkg::result_t                res_q, res_d;

  logic [pfba_pkg::WORD_W-1:0]      bm_mem [WORDS];
  logic [pfba_pkg::WORD_W-1:0]      sum_mem [SR];
  logic [pfba_pkg::WORD_W-1:0]      bm_rdata_q, sum_rdata_q;
  logic                             bm_re, sum_re, bm_we, sum_we;
  logic [WA-1:0]                    bm_raddr;
  logic [SRA-1:0]                   sum_raddr;
  logic [pfba_pkg::WORD_W-1:0]      bm_wdata, sum_wdata;

  logic                             accept;
  logic [pfba_pkg::WORD_IDX_W-1:0]  in_word, word_q, rd_word;
  logic [pfba_pkg::BIT_IDX_W-1:0]   top_row, sum_col, a_bit, tgt_bit;
  logic                             top_hit, change;
  logic [pfba_pkg::WORD_W-1:0]      sum_row, bm_word, new_word, new_sum, bit_mask;

  pfba_pkg::div_req_t               div_req;
  pfba_pkg::div_rsp_t               div_rsp;

  pfba_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_FIN);
  assign res_o       = res_q;

  assign in_word = in_frame_i[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_IDX_W];
  assign word_q  = {row_q, col_q};
  assign top_row = pfba_pkg::lowest_set(pfba_pkg::WORD_W'(top_q));

  // A clear summary flag means the entry below is all used, whatever the memory holds.
  assign top_hit  = in_range_q && top_q[row_q[SRA-1:0]];
  assign sum_row  = top_hit ? sum_rdata_q : '0;
  assign sum_col  = pfba_pkg::lowest_set(sum_row);
  assign bm_word  = sum_row[col_q] ? bm_rdata_q : '0;
  assign a_bit    = pfba_pkg::lowest_set(bm_word);
  assign tgt_bit  = (op_q == pfba_pkg::OP_ALLOC) ? a_bit : bit_q;
  assign bit_mask = pfba_pkg::WORD_W'(1) << tgt_bit;

  assign div_req.start    = accept && (in_op_i == pfba_pkg::OP_QUERY);
  assign div_req.dividend = {free_q, {pfba_pkg::PAGE_SHIFT{1'b0}}};
  assign div_req.divisor  = (in_divisor_i == '0) ? pfba_pkg::DIV_W'(1) : in_divisor_i;

  always_comb begin
    new_word = bm_word & ~bit_mask;
    change   = bm_word[tgt_bit];
    if (op_q == pfba_pkg::OP_FREE) begin
      new_word = bm_word | bit_mask;
      change   = !bm_word[tgt_bit];
    end
    new_sum          = sum_row;
    new_sum[col_q]   = |new_word;
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    row_d      = row_q;
    col_d      = col_q;
    bit_d      = bit_q;
    in_range_d = in_range_q;
    free_d     = free_q;
    top_d      = top_q;
    res_d      = res_q;
    sum_re     = 1'b0;
    sum_raddr  = row_q[SRA-1:0];
    bm_re      = 1'b0;
    rd_word    = in_word;
    bm_we      = 1'b0;
    sum_we     = 1'b0;
    bm_wdata   = new_word;
    sum_wdata  = new_sum;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = in_op_i;
          res_d = '0;
          case (in_op_i)
            pfba_pkg::OP_ALLOC: begin
              row_d      = top_row;
              in_range_d = 1'b1;
              sum_raddr  = top_row[SRA-1:0];
              if (top_q == '0) begin
                state_d = ST_FIN;
              end else begin
                sum_re  = 1'b1;
                state_d = ST_ASUM;
              end
            end
            pfba_pkg::OP_FREE, pfba_pkg::OP_MARK: begin
              row_d      = in_word[pfba_pkg::WORD_IDX_W-1:pfba_pkg::BIT_IDX_W];
              col_d      = in_word[pfba_pkg::BIT_IDX_W-1:0];
              bit_d      = in_frame_i[pfba_pkg::BIT_IDX_W-1:0];
              in_range_d = {1'b0, in_word} < WORDS_LIM;
              sum_raddr  = row_d[SRA-1:0];
              sum_re     = 1'b1;
              bm_re      = 1'b1;
              state_d    = ST_RMW;
            end
            pfba_pkg::OP_QUERY: begin
              state_d = ST_DIV;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_ASUM: begin
        // summary word is back: pick the lowest nonempty bitmap word
        col_d   = sum_col;
        rd_word = {row_q, sum_col};
        bm_re   = 1'b1;
        state_d = ST_RMW;
      end
      ST_RMW: begin
        if (in_range_q && change) begin
          bm_we                = 1'b1;
          sum_we               = 1'b1;
          top_d[row_q[SRA-1:0]] = |new_sum;
          free_d = (op_q == pfba_pkg::OP_FREE) ? free_q + pfba_pkg::COUNT_W'(1) :
                                                 free_q - pfba_pkg::COUNT_W'(1);
        end
        if (op_q == pfba_pkg::OP_ALLOC) begin
          res_d.alloc_frame = {row_q, col_q, a_bit};
          res_d.found       = 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_d.free_space = div_rsp.quotient;
          state_d          = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    bm_raddr = rd_word[WA-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= pfba_pkg::OP_ALLOC;
      in_range_q <= 1'b0;
      free_q     <= '0;
      top_q      <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      in_range_q <= in_range_d;
      free_q     <= free_d;
      top_q      <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    bit_q <= bit_d;
    res_q <= res_d;
  end

  // Writes land in ST_RMW, before ST_FIN lets the next accept in, so reads never see stale data.
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[word_q[WA-1:0]] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rdata_q <= bm_mem[bm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[row_q[SRA-1:0]] <= sum_wdata;
    end
    if (sum_re) begin
      sum_rdata_q <= sum_mem[sum_raddr];
    end
  end

  a_alloc_hits_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW && op_q == pfba_pkg::OP_ALLOC) |-> (bm_word != '0))
    else $error("allocate reached a bitmap word with no free frame");

  a_write_in_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bm_we || sum_we) |-> (state_q == ST_RMW && in_range_q))
    else $error("memory write outside read-modify-write");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FRAME_LIM)
    else $error("free frame count beyond bitmap size");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside a query");

endmodule

>>> hw/rtl/page_frame_bitmap_allocator_top.sv
// Top level of the page frame bitmap allocator: stream ports and output register.
//
//   channel  | dir | tdata (low bit up)                    | tuser
//   s_axis   | in  | frame_number[14:0], divisor[46:15]    | op[1:0]
//   m_axis   | out | alloc_frame[14:0], free_space[42:15]  | found[0]
//
// Free and mark-used read the word, write it back and hand off; allocate steps through summary
// read, bitmap read, write back and hand-off; query waits on the one-bit-per-cycle divider.
// Reset clears the summary flags at once; no memory clearing pass is needed.
// One result word waits in the output register while the next input word is taken;
// the sequencer holds its finished result while that register is full and not being drained.
module page_frame_bitmap_allocator_top #(
  parameter int unsigned BITMAP_WORDS = pfba_pkg::BITMAP_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // frame_number[14:0], divisor[46:15]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // alloc_frame[14:0], free_space[42:15]
  output logic [0:0]  m_axis_tuser_o    // found[0]
);

  logic              res_valid, res_ready;
  pfba_pkg::result_t res;
  logic              out_valid_q, out_valid_d;
  pfba_pkg::result_t out_q, out_d;

  pfba_core #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_op_i      (pfba_pkg::op_e'(s_axis_tuser_i)),
    .in_frame_i   (s_axis_tdata_i[14:0]),
    .in_divisor_i (s_axis_tdata_i[46:15]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_q.free_space, out_q.alloc_frame};
  assign m_axis_tuser_o  = out_q.found;

endmodule
